[rtl/fwmm_pkg.sv]
// Package with the constants, register indexes and root table of the fuzzy weighted min/max/mean unit.
package fwmm_pkg;

    localparam int Q_W          = 17;
    localparam int SUM_W        = 20;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_WEIGHTS  = 6;
    localparam int MAX_CRITERIA = 6;
    localparam int FRAC_BITS    = 24;
    localparam int MANT_W       = 32;
    localparam int ROOT_W       = 33;

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_CRITERIA_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FIRST   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST    = CFG_IDX_W'(NUM_WEIGHTS);

    typedef logic [FRAC_BITS:0][ROOT_W-1:0] root_table_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'h4000_0000_0000_0000;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry k holds 2^(-2^-k) in Q1.32; entry 0 is 1.0.
    function automatic root_table_t build_root_table();
        root_table_t t;
        logic [63:0] s;
        t[0] = ROOT_W'(64'h1_0000_0000);
        s    = isqrt64(64'h8000_0000_0000_0000);
        t[1] = ROOT_W'(s);
        for (int k = 2; k <= FRAC_BITS; k++) begin
            s    = isqrt64({t[k-1][31:0], 32'd0});
            t[k] = ROOT_W'(s);
        end
        return t;
    endfunction

    localparam root_table_t ROOT_TABLE = build_root_table();

endpackage

[rtl/fuzzy_weighted_min_max_mean_unit.sv]
// Top level of the fuzzy weighted min/max/mean unit with its shared multiplier sequencer.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: membership
// m_        out  m_tvalid/m_tready  m_tdata: and_value, or_value, mean_value
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A membership value is worked through the log, scale, exp, round and accumulate states before the next
// one can be taken, or only the accumulate state when the weight or value makes the power trivial; the
// 33x32 multiplier is shared by 24 log squaring steps, one scaling step and 24 root steps.
// The value that closes a pixel also passes through the bit-serial mean division and the output load,
// and waits further while an earlier result has not been taken.
// Reset is synchronous and active low; configuration writes are always accepted.
module fuzzy_weighted_min_max_mean_unit
    import fwmm_pkg::*;
#(
    parameter int CRITERIA_MAX = MAX_CRITERIA
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [16:0] membership
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // [16:0] and_value, [33:17] or_value,
                                            // [50:34] mean_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOG   = 8'b0000_0010,
        ST_SCALE = 8'b0000_0100,
        ST_EXP   = 8'b0000_1000,
        ST_ROUND = 8'b0001_0000,
        ST_ACCUM = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      count_cfg_reg;
    logic [Q_W-1:0]        weight_reg [NUM_WEIGHTS];
    logic [IDX_W-1:0]      idx_reg;
    logic [Q_W-1:0]        running_min_reg;
    logic [Q_W-1:0]        running_max_reg;
    logic [SUM_W-1:0]      running_sum_reg;

    logic [Q_W-1:0]        w_reg;
    logic [3:0]            e_reg;
    logic [MANT_W-1:0]     m_reg;
    logic [FRAC_BITS-1:0]  f_reg;
    logic [4:0]            step_reg;
    logic [5:0]            n_reg;
    logic [FRAC_BITS-1:0]  g_reg;
    logic [ROOT_W-1:0]     r_reg;
    logic [Q_W-1:0]        v_reg;
    logic [SUM_W-1:0]      q_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [IDX_W-1:0]      div_count_reg;

    logic                  m_tvalid_reg;
    logic [Q_W-1:0]        and_reg;
    logic [Q_W-1:0]        or_reg;
    logic [Q_W-1:0]        mean_reg;

    logic [Q_W-1:0]        x_raw;
    logic [Q_W-1:0]        x_sat;
    logic [Q_W-1:0]        w_raw;
    logic [Q_W-1:0]        w_sat;
    logic                  trivial;
    logic [Q_W-1:0]        trivial_value;
    logic [3:0]            e_top;
    logic [28:0]           lmag;
    logic [ROOT_W-1:0]     mul_a;
    logic [MANT_W-1:0]     mul_b;
    logic [64:0]           mul_p;
    logic [32:0]           sq;
    logic [33:0]           rnd_sum;
    logic [33:0]           rnd_shift;
    logic [Q_W-1:0]        v_round;
    logic [IDX_W-1:0]      count_eff;
    logic [IDX_W-1:0]      idx_inc;
    logic                  pixel_done;
    logic [Q_W-1:0]        min_next;
    logic [Q_W-1:0]        max_next;
    logic [SUM_W-1:0]      sum_next;
    logic [IDX_W:0]        trial;
    logic                  s_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'd0, mean_reg, or_reg, and_reg};

    always_comb begin
        x_raw = s_tdata[Q_W-1:0];
        x_sat = (x_raw > ONE_Q16) ? ONE_Q16 : x_raw;
        w_raw = ONE_Q16;
        if (idx_reg < IDX_W'(NUM_WEIGHTS)) begin
            w_raw = weight_reg[idx_reg];
        end
        w_sat = (w_raw > ONE_Q16) ? ONE_Q16 : w_raw;

        trivial       = 1'b1;
        trivial_value = ONE_Q16;
        if (w_sat == '0) begin
            trivial_value = ONE_Q16;
        end else if (x_sat == '0) begin
            trivial_value = '0;
        end else if (x_sat == ONE_Q16) begin
            trivial_value = ONE_Q16;
        end else if (w_sat == ONE_Q16) begin
            trivial_value = x_sat;
        end else begin
            trivial = 1'b0;
        end

        e_top = '0;
        for (int i = 0; i < 16; i++) begin
            if (x_sat[i]) begin
                e_top = 4'(i);
            end
        end
    end

    assign lmag = {5'd16 - {1'b0, e_reg}, 24'd0} - {5'd0, f_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LOG: begin
                mul_a = {1'b0, m_reg};
                mul_b = m_reg;
            end
            ST_SCALE: begin
                mul_a = {4'd0, lmag};
                mul_b = {15'd0, w_reg};
            end
            ST_EXP: begin
                mul_a = r_reg;
                mul_b = ROOT_TABLE[step_reg][MANT_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {32'd0, mul_a} * {33'd0, mul_b};
        sq    = mul_p[63:31];
    end

    always_comb begin
        rnd_sum   = {1'b0, r_reg} + (34'd1 << (7'd15 + {1'b0, n_reg}));
        rnd_shift = rnd_sum >> (7'd16 + {1'b0, n_reg});
        if (n_reg >= 6'd18) begin
            v_round = '0;
        end else if (rnd_shift > {17'd0, ONE_Q16}) begin
            v_round = ONE_Q16;
        end else begin
            v_round = rnd_shift[Q_W-1:0];
        end
    end

    always_comb begin
        if (count_cfg_reg == '0) begin
            count_eff = IDX_W'(1);
        end else if (count_cfg_reg > IDX_W'(CRITERIA_MAX)) begin
            count_eff = IDX_W'(CRITERIA_MAX);
        end else begin
            count_eff = count_cfg_reg;
        end
        idx_inc    = idx_reg + IDX_W'(1);
        pixel_done = (idx_inc >= count_eff) || (idx_inc == '0);

        if (idx_reg == '0) begin
            min_next = v_reg;
            max_next = v_reg;
            sum_next = {3'd0, v_reg};
        end else begin
            min_next = (v_reg < running_min_reg) ? v_reg : running_min_reg;
            max_next = (v_reg > running_max_reg) ? v_reg : running_max_reg;
            sum_next = running_sum_reg + {3'd0, v_reg};
        end

        trial = {rem_reg, q_reg[SUM_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= IDX_W'(1);
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                weight_reg[i] <= ONE_Q16;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_CRITERIA_COUNT) begin
                count_cfg_reg <= cfg_data[IDX_W-1:0];
            end else if (cfg_index >= REG_WEIGHT_FIRST && cfg_index <= REG_WEIGHT_LAST) begin
                weight_reg[cfg_index - REG_WEIGHT_FIRST] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            running_min_reg <= '0;
            running_max_reg <= '0;
            running_sum_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        w_reg    <= w_sat;
                        e_reg    <= e_top;
                        m_reg    <= MANT_W'({15'd0, x_sat} << (5'd31 - {1'b0, e_top}));
                        f_reg    <= '0;
                        step_reg <= '0;
                        v_reg    <= trivial_value;
                        state_reg <= trivial ? ST_ACCUM : ST_LOG;
                    end
                end
                ST_LOG: begin
                    if (sq[32]) begin
                        m_reg <= sq[32:1];
                    end else begin
                        m_reg <= sq[31:0];
                    end
                    f_reg <= {f_reg[FRAC_BITS-2:0], sq[32]};
                    if (step_reg == 5'(FRAC_BITS - 1)) begin
                        state_reg <= ST_SCALE;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_SCALE: begin
                    n_reg     <= mul_p[45:40];
                    g_reg     <= mul_p[39:16];
                    r_reg     <= ROOT_TABLE[0];
                    step_reg  <= 5'd1;
                    state_reg <= ST_EXP;
                end
                ST_EXP: begin
                    if (g_reg[FRAC_BITS-1]) begin
                        r_reg <= mul_p[64:32];
                    end
                    g_reg <= {g_reg[FRAC_BITS-2:0], 1'b0};
                    if (step_reg == 5'(FRAC_BITS)) begin
                        state_reg <= ST_ROUND;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_ROUND: begin
                    v_reg     <= v_round;
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    running_min_reg <= min_next;
                    running_max_reg <= max_next;
                    running_sum_reg <= sum_next;
                    if (pixel_done) begin
                        idx_reg       <= '0;
                        q_reg         <= sum_next;
                        rem_reg       <= '0;
                        div_count_reg <= count_eff;
                        step_reg      <= '0;
                        state_reg     <= ST_DIV;
                    end else begin
                        idx_reg   <= idx_inc;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (trial >= {1'b0, div_count_reg}) begin
                        rem_reg <= IDX_W'(trial - {1'b0, div_count_reg});
                        q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[IDX_W-1:0];
                        q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
                    end
                    if (step_reg == 5'(SUM_W - 1)) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        and_reg      <= running_min_reg;
                        or_reg       <= running_max_reg;
                        mean_reg     <= q_reg[Q_W-1:0];
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The criterion index never reaches the largest allowed count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < IDX_W'(CRITERIA_MAX))
        else $error("criterion index out of range");

    // Within a pixel the running minimum never exceeds the running maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> running_min_reg <= running_max_reg)
        else $error("running minimum above running maximum");

    // An accepted request starts work, so no second request follows at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request accepted while busy");

    // A result appears only when the sequencer loads the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the output load");

    // A shown result is ordered and within one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (and_reg <= or_reg) && (or_reg <= ONE_Q16))
        else $error("result fields out of order or range");
`endif

endmodule

[tb/sv/testbench.sv]
// Testbench for the fuzzy weighted min/max/mean unit: stream stimulus against a predictor.
`timescale 1ns / 100ps

module testbench;
    import fwmm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [Q_W-1:0] and_v;
        logic [Q_W-1:0] or_v;
        logic [Q_W-1:0] mean_v;
    } pixel_result_t;

    class pixel_scoreboard;
        logic [63:0]      roots[FRAC_BITS+1];
        logic [IDX_W-1:0] count_reg;
        logic [Q_W-1:0]   weights[NUM_WEIGHTS];
        logic [IDX_W-1:0] crit_idx;
        logic [Q_W-1:0]   run_min;
        logic [Q_W-1:0]   run_max;
        logic [SUM_W-1:0] run_sum;
        pixel_result_t    expected_pixels[$];
        int unsigned      mismatches;

        function new();
            count_reg = IDX_W'(1);
            foreach (weights[i]) weights[i] = ONE_Q16;
            crit_idx   = '0;
            run_min    = '0;
            run_max    = '0;
            run_sum    = '0;
            mismatches = 0;
            roots[0] = 64'd1 << 32;
            roots[1] = floor_sqrt(64'd1 << 63);
            for (int k = 2; k <= FRAC_BITS; k++) roots[k] = floor_sqrt(roots[k-1] << 32);
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] c;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        // Power by log2 from repeated squaring, scaling, and a product of roots of one half.
        function logic [Q_W-1:0] weighted_power(logic [Q_W-1:0] x, logic [Q_W-1:0] w);
            int          e;
            int unsigned n;
            logic [63:0] mant;
            logic [63:0] frac;
            logic [63:0] lmag;
            logic [63:0] p;
            logic [63:0] r;
            logic [23:0] g;
            if (w == 0) return ONE_Q16;
            if (x == 0) return '0;
            if (x >= ONE_Q16) return ONE_Q16;
            if (w >= ONE_Q16) return x;
            e = 15;
            while (e > 0 && !x[e]) e--;
            mant = 64'(x) << (31 - e);
            frac = '0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                mant = (mant * mant) >> 31;
                frac = frac << 1;
                if (mant >= (64'd1 << 32)) begin
                    mant = mant >> 1;
                    frac[0] = 1'b1;
                end
            end
            lmag = (64'(16 - e) << FRAC_BITS) - frac;
            p = (lmag * 64'(w)) >> 16;
            n = int'(p >> FRAC_BITS);
            if (n >= 18) return '0;
            g = p[23:0];
            r = 64'd1 << 32;
            for (int k = 1; k <= FRAC_BITS; k++) begin
                if (g[FRAC_BITS-k]) r = (r * roots[k]) >> 32;
            end
            r = ((r << 16) + (64'd1 << (31 + n))) >> (32 + n);
            if (r > 64'(ONE_Q16)) r = 64'(ONE_Q16);
            return r[Q_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
            if (idx == REG_CRITERIA_COUNT) begin
                count_reg = data[IDX_W-1:0];
            end else if (idx >= REG_WEIGHT_FIRST && idx <= REG_WEIGHT_LAST) begin
                weights[idx - REG_WEIGHT_FIRST] = data;
            end
        endfunction

        function void note_membership(logic [Q_W-1:0] raw);
            logic [Q_W-1:0] x;
            logic [Q_W-1:0] w;
            logic [Q_W-1:0] v;
            int unsigned    eff;
            pixel_result_t  res;
            x = (raw > ONE_Q16) ? ONE_Q16 : raw;
            w = (crit_idx < NUM_WEIGHTS) ? weights[crit_idx] : ONE_Q16;
            if (w > ONE_Q16) w = ONE_Q16;
            v = weighted_power(x, w);
            if (crit_idx == 0) begin
                run_min = v;
                run_max = v;
                run_sum = SUM_W'(v);
            end else begin
                if (v < run_min) run_min = v;
                if (v > run_max) run_max = v;
                run_sum = run_sum + SUM_W'(v);
            end
            crit_idx = crit_idx + IDX_W'(1);
            eff = count_reg;
            if (eff == 0) eff = 1;
            if (eff > MAX_CRITERIA) eff = MAX_CRITERIA;
            if (crit_idx >= eff || crit_idx == 0) begin
                res.and_v  = run_min;
                res.or_v   = run_max;
                res.mean_v = Q_W'(run_sum / eff);
                expected_pixels.push_back(res);
                crit_idx = '0;
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [55:0] data);
            pixel_result_t exp_r;
            if (expected_pixels.size() == 0) begin
                report($sformatf("result 0x%0h arrived with no pixel pending", data));
            end else begin
                exp_r = expected_pixels.pop_front();
                if (data[16:0] !== exp_r.and_v)
                    report($sformatf("and_value got %0d expected %0d", data[16:0], exp_r.and_v));
                if (data[33:17] !== exp_r.or_v)
                    report($sformatf("or_value got %0d expected %0d", data[33:17], exp_r.or_v));
                if (data[50:34] !== exp_r.mean_v)
                    report($sformatf("mean_value got %0d expected %0d",
                                     data[50:34], exp_r.mean_v));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // [16:0] membership
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;   // [16:0] and_value, [33:17] or_value, [50:34] mean_value
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]       cfg_data;

    pixel_scoreboard sb;
    bit              idle_on;
    int unsigned     sent;

    fuzzy_weighted_min_max_mean_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // All driver tasks are entered and left at a falling edge.
    task automatic send_membership(input logic [Q_W-1:0] x);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_membership(x);
        sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [Q_W-1:0] random_q16();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return ONE_Q16 + Q_W'($urandom_range(1, 65535));
            3:       return Q_W'(1);
            4:       return Q_W'(65535);
            default: return Q_W'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [Q_W-1:0] vals[$];
        bit             last_stretch;
        sb        = new();
        idle_on   = 1'b1;
        sent      = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: one criterion per pixel, all weights 1.0, saturation of input.
        vals = '{17'd0, ONE_Q16, 17'h1FFFF, 17'd1, 17'd32768};
        foreach (vals[i]) send_membership(vals[i]);
        drain();

        // Zero weight with zero input, full weight, and a weight above 1.0.
        write_reg(REG_CRITERIA_COUNT, Q_W'(3));
        write_reg(REG_WEIGHT_FIRST, '0);
        write_reg(REG_WEIGHT_FIRST + 1, ONE_Q16);
        write_reg(REG_WEIGHT_FIRST + 2, 17'h1FFFF);
        vals = '{17'd0, 17'd5, ONE_Q16};
        foreach (vals[i]) send_membership(vals[i]);
        drain();

        // Six criteria with small, middle and near-full weights, then a partial pixel.
        write_reg(REG_CRITERIA_COUNT, Q_W'(6));
        vals = '{17'd1, 17'd32768, 17'd65535, 17'd100, 17'd40000, 17'h10001};
        foreach (vals[i]) write_reg(REG_WEIGHT_FIRST + CFG_IDX_W'(i), vals[i]);
        vals = '{17'd1, 17'd65535, 17'd1, 17'd300, 17'd2, 17'h1FFFF,
                 17'h0ABCD, 17'h01234, 17'd7};
        foreach (vals[i]) send_membership(vals[i]);
        drain();

        // Lowering the count mid-pixel closes the pixel on the next value.
        write_reg(REG_CRITERIA_COUNT, Q_W'(2));
        send_membership(17'd40000);
        drain();

        // Count zero acts as one; count seven acts as the maximum; index seven is ignored.
        write_reg(REG_CRITERIA_COUNT, 17'h10008);
        send_membership(17'd777);
        drain();
        write_reg(REG_CRITERIA_COUNT, 17'h0000F);
        write_reg(REG_UNMAPPED, Q_W'($urandom_range(0, 131071)));
        repeat (6) send_membership(random_q16());
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            last_stretch = (sent + 250 >= RANDOM_ITEMS);
            idle_on = last_stretch ? 1'b0 : ($urandom_range(0, 3) != 0);
            drain();
            write_reg(REG_CRITERIA_COUNT, {14'($urandom_range(0, 16383)),
                                           3'($urandom_range(0, 7))});
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                if ($urandom_range(0, 2) != 0)
                    write_reg(REG_WEIGHT_FIRST + CFG_IDX_W'(i), random_q16());
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNMAPPED, Q_W'($urandom_range(0, 131071)));
            repeat ($urandom_range(10, 80)) send_membership(random_q16());
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
